FILE: hdl/icymd_pkg.sv
`timescale 1ns / 1ps
package icymd_pkg;

	localparam int FieldMaxDefault = 255;

	localparam int TitleNameLen = 11;
	localparam int UrlNameLen   = 9;
	localparam int TitleValPos  = 12;
	localparam int UrlValPos    = 10;

	localparam logic [2:0] KIND_AUDIO     = 3'd0;
	localparam logic [2:0] KIND_LENGTH    = 3'd1;
	localparam logic [2:0] KIND_META      = 3'd2;
	localparam logic [2:0] KIND_TITLE     = 3'd3;
	localparam logic [2:0] KIND_URL       = 3'd4;
	localparam logic [2:0] KIND_TITLE_END = 3'd5;
	localparam logic [2:0] KIND_URL_END   = 3'd6;

	localparam logic [7:0] CHAR_SEMI  = 8'h3B;
	localparam logic [7:0] CHAR_QUOTE = 8'h27;

	typedef struct packed {
		logic [7:0] stream_byte;
		logic       stream_start;
	} stream_in_t;

	typedef struct packed {
		logic [2:0] byte_kind;
		logic [7:0] data_byte;
	} result_t;

	// Control from the stream sequencer to the field parser.
	typedef struct packed {
		logic fire;
		logic clear;
	} field_ctl_t;

	function automatic logic [7:0] title_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = "S";
			4'd1:    c = "t";
			4'd2:    c = "r";
			4'd3:    c = "e";
			4'd4:    c = "a";
			4'd5:    c = "m";
			4'd6:    c = "T";
			4'd7:    c = "i";
			4'd8:    c = "t";
			4'd9:    c = "l";
			4'd10:   c = "e";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] url_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = "S";
			4'd1:    c = "t";
			4'd2:    c = "r";
			4'd3:    c = "e";
			4'd4:    c = "a";
			4'd5:    c = "m";
			4'd6:    c = "U";
			4'd7:    c = "r";
			4'd8:    c = "l";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

FILE: hdl/icymd_field.sv
`timescale 1ns / 1ps
module icymd_field #(
	parameter int FIELD_MAX = icymd_pkg::FieldMaxDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  icymd_pkg::field_ctl_t  ctl,
	input  logic [7:0]             char_in,
	output logic [2:0]             kind
);
	import icymd_pkg::*;

	localparam int FW = $clog2(FIELD_MAX + 1);

	logic [FW-1:0] fp_q;
	logic          title_q;
	logic          url_q;

	logic [FW-1:0] fp_d;
	logic          title_d;
	logic          url_d;
	logic          title_n;
	logic          url_n;

	always_comb begin
		kind    = KIND_META;
		fp_d    = fp_q;
		title_d = title_q;
		url_d   = url_q;
		title_n = title_q;
		url_n   = url_q;
		if (char_in == CHAR_SEMI) begin
			if (title_q && fp_q > FW'(TitleValPos)) begin
				kind = KIND_TITLE_END;
			end else if (url_q && fp_q > FW'(UrlValPos)) begin
				kind = KIND_URL_END;
			end
			fp_d    = '0;
			title_d = 1'b1;
			url_d   = 1'b1;
		end else if (char_in == CHAR_QUOTE) begin
			kind = KIND_META;
		end else if (fp_q < FW'(FIELD_MAX)) begin
			if (fp_q < FW'(TitleNameLen) && char_in != title_char(fp_q[3:0])) begin
				title_n = 1'b0;
			end
			if (fp_q < FW'(UrlNameLen) && char_in != url_char(fp_q[3:0])) begin
				url_n = 1'b0;
			end
			if (title_n && fp_q >= FW'(TitleValPos)) begin
				kind = KIND_TITLE;
			end else if (url_n && fp_q >= FW'(UrlValPos)) begin
				kind = KIND_URL;
			end
			title_d = title_n;
			url_d   = url_n;
			fp_d    = fp_q + FW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q    <= '0;
			title_q <= 1'b1;
			url_q   <= 1'b1;
		end else if (ctl.clear) begin
			fp_q    <= '0;
			title_q <= 1'b1;
			url_q   <= 1'b1;
		end else if (ctl.fire) begin
			fp_q    <= fp_d;
			title_q <= title_d;
			url_q   <= url_d;
		end
	end

endmodule

FILE: hdl/icy_metadata_demux_core.sv
`timescale 1ns / 1ps
// Splits an ICY stream body into audio and in-band metadata, one byte per
// transaction, and gives one result per byte naming what the byte is: audio,
// the length byte, plain metadata, a StreamTitle or StreamUrl value character,
// or the end of such a value. meta_interval sets the audio run between
// metadata blocks; zero passes everything as audio. A byte is classified in
// the cycle it is accepted and its result is held in the output register, so
// the block takes one byte every clock cycle; in_ready drops only while a
// result sits in the output register and out_ready is low.
module icy_metadata_demux_core #(
	parameter int FIELD_MAX = icymd_pkg::FieldMaxDefault
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [15:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  icymd_pkg::stream_in_t in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output icymd_pkg::result_t    out_data
);
	import icymd_pkg::*;

	localparam logic [1:0] PH_AUDIO = 2'd0;
	localparam logic [1:0] PH_LEN   = 2'd1;
	localparam logic [1:0] PH_META  = 2'd2;

	logic [15:0] meta_interval_q;
	logic [1:0]  phase_q;
	logic [15:0] audio_count_q;
	logic [11:0] meta_rem_q;
	logic        out_valid_q;
	result_t     out_q;

	logic        acc;
	logic [1:0]  phase_eff;
	logic [15:0] count_eff;
	logic [11:0] rem_eff;
	logic [11:0] rem_dec;
	logic [16:0] count_inc;
	logic [1:0]  phase_d;
	logic [15:0] count_d;
	logic [11:0] rem_d;
	logic [2:0]  kind;
	logic [2:0]  field_kind;
	field_ctl_t  fctl;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign acc       = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A new connection restarts the stream before its first byte is handled.
	assign phase_eff = in_data.stream_start ? PH_AUDIO : phase_q;
	assign count_eff = in_data.stream_start ? '0 : audio_count_q;
	assign rem_eff   = in_data.stream_start ? '0 : meta_rem_q;
	assign rem_dec   = rem_eff - 12'd1;
	assign count_inc = {1'b0, count_eff} + 17'd1;

	always_comb begin
		kind       = KIND_AUDIO;
		phase_d    = PH_AUDIO;
		count_d    = count_eff;
		rem_d      = rem_eff;
		fctl.fire  = 1'b0;
		fctl.clear = acc && in_data.stream_start;
		case (phase_eff)
			PH_LEN: begin
				kind       = KIND_LENGTH;
				rem_d      = {in_data.stream_byte, 4'b0000};
				phase_d    = (in_data.stream_byte != 8'd0) ? PH_META : PH_AUDIO;
				fctl.clear = acc;
			end
			PH_META: begin
				kind      = field_kind;
				rem_d     = rem_dec;
				fctl.fire = acc;
				if (rem_dec == 12'd0) begin
					phase_d    = PH_AUDIO;
					fctl.clear = acc;
				end else begin
					phase_d = PH_META;
				end
			end
			default: begin
				kind = KIND_AUDIO;
				if (meta_interval_q != 16'd0) begin
					if (count_inc >= {1'b0, meta_interval_q}) begin
						count_d = '0;
						phase_d = PH_LEN;
					end else begin
						count_d = count_inc[15:0];
					end
				end
			end
		endcase
	end

	icymd_field #(
		.FIELD_MAX(FIELD_MAX)
	) u_field (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (fctl),
		.char_in (in_data.stream_byte),
		.kind    (field_kind)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_interval_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			meta_interval_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_AUDIO;
			audio_count_q <= '0;
			meta_rem_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (acc) begin
				phase_q       <= phase_d;
				audio_count_q <= count_d;
				meta_rem_q    <= rem_d;
				out_valid_q   <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			out_q.byte_kind <= kind;
			out_q.data_byte <= in_data.stream_byte;
		end
	end

	// Inside a metadata block there is always at least one byte left to come.
	a_meta_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_META |-> meta_rem_q != 12'd0)
		else $error("metadata phase with no bytes remaining");

	// With extraction disabled, an audio byte never leads to a length byte.
	a_interval_off: assert property (@(posedge clk) disable iff (!arst_n)
		acc && meta_interval_q == 16'd0 && phase_q != PH_LEN && phase_q != PH_META
		|=> phase_q == PH_AUDIO)
		else $error("metadata phase entered with interval zero");

	// A field end is only ever reported on the separator character.
	a_end_on_semi: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.byte_kind == KIND_TITLE_END || out_q.byte_kind == KIND_URL_END)
		|-> out_q.data_byte == CHAR_SEMI)
		else $error("field end reported on a non-separator byte");

endmodule
